FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// same, on the block clock and reset
`define ASSERT_CLK(lbl, prop) `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/core/esrs_pkg.sv
package esrs_pkg;

  // default depth of the averaging window
  localparam int unsigned DEF_WINDOW = 25;

  // field widths
  localparam int unsigned POS_W     = 32;
  localparam int unsigned TGT_W     = 15;
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned SPD_W     = 23;
  localparam int unsigned RAMP_W    = 25;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  // |target| * 2000 fits here
  localparam int unsigned RPROD_W   = 25;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIME = 2'd1;

  // scale factors
  localparam int SPEED_SCALE = 75;
  localparam int RAMP_SCALE  = 2000;
  localparam int GOAL_SCALE  = 1000;

  // delta saturation limits
  localparam int DELTA_MAX = 32767;
  localparam int DELTA_MIN = -32768;

  // setpoint range
  localparam int RAMP_MIN = -16384000;
  localparam int RAMP_MAX = 16383000;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic ring;
    logic mul;
    logic div_start;
    logic spd_cap;
    logic ramp_upd;
    logic out_load;
  } esrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
  } esrs_sts_t;

endpackage

FILE: rtl/core/esrs_ram.sv
module esrs_ram
  import esrs_pkg::*;
#(
  parameter int unsigned WIDTH = DELTA_W,
  parameter int unsigned DEPTH = DEF_WINDOW,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/esrs_div.sv
module esrs_div
  import esrs_pkg::*;
#(
  parameter int unsigned DVD_W = 28,
  parameter int unsigned DVS_W = TIME_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  // two quotient bits per cycle
  localparam int unsigned STEPS = (DVD_W + 1) / 2;
  localparam int unsigned PAD_W = 2 * STEPS;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PAD_W-1:0] dq_q, dq_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;

  // restoring division, two dependent steps
  always_comb begin
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] r;
    logic [PAD_W-1:0] d;
    r = rem_q;
    d = dq_q;
    for (int i = 0; i < 2; i++) begin
      trial = {r, d[PAD_W-1]};
      diff  = trial - {1'b0, dvs_q};
      ge    = (trial >= {1'b0, dvs_q});
      r     = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      d     = {d[PAD_W-2:0], ge};
    end
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = PAD_W'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = d;
      rem_d = r;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = dq_q[DVD_W-1:0];

endmodule

FILE: rtl/core/esrs_ctrl.sv
module esrs_ctrl
  import esrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  esrs_sts_t sts_i,
  output esrs_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RING = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DSPD = 3'd3;
  localparam logic [2:0] ST_DRMP = 3'd4;
  localparam logic [2:0] ST_WRMP = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  esrs_cmd_t  cmd;

  // sequencing of one transaction
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_RING;
        end
      end
      ST_RING: begin
        cmd.ring = 1'b1;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_d = ST_DSPD;
      end
      ST_DSPD: begin
        cmd.spd_cap = 1'b1;
        state_d     = ST_DRMP;
      end
      ST_DRMP: begin
        cmd.div_start = 1'b1;
        state_d       = ST_WRMP;
      end
      ST_WRMP: begin
        if (!sts_i.div_busy) begin
          cmd.ramp_upd = 1'b1;
          state_d      = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

FILE: rtl/core/esrs_dpath.sv
module esrs_dpath
  import esrs_pkg::*;
#(
  parameter int unsigned WINDOW = DEF_WINDOW,
  parameter int unsigned SUM_W  = 21,
  parameter int unsigned DVD_W  = 28
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  esrs_cmd_t                cmd_i,
  output esrs_sts_t                sts_o,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [TIME_W-1:0]        cfg_data_i,
  input  logic signed [POS_W-1:0]  encoder_position_i,
  input  logic signed [TGT_W-1:0]  target_rpm_i,
  input  logic                     stop_event_i,
  output logic signed [SPD_W-1:0]  speed_decirpm_o,
  output logic signed [RAMP_W-1:0] ramp_setpoint_mrpm_o,
  output logic                     stop_active_o
);

  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned PROD_W = SUM_W + 8;
  localparam int unsigned MAG_W  = SUM_W + 6;
  localparam int unsigned WIDE_W = RAMP_W + 2;
  // reciprocal of the window depth, exact floor for dividends below 2^MAG_W
  localparam int unsigned RSH    = MAG_W + $clog2(WINDOW);
  localparam int unsigned RCP_W  = MAG_W + 1;
  localparam longint unsigned RCP =
    ((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  // configuration
  logic [TIME_W-1:0] rise_q, fall_q;

  // tick state
  logic [POS_W-1:0]         last_pos_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic signed [TGT_W-1:0]  tgt_q;
  logic                     latch_q;
  logic [PTR_W-1:0]         ptr_q;
  logic [WINDOW-1:0]        vld_q;
  logic signed [SUM_W-1:0]  total_q;
  logic [MAG_W-1:0]         spd_dvd_q;
  logic                     spd_neg_q;
  logic [RPROD_W-1:0]       rprod_q;
  logic signed [SPD_W-1:0]  speed_q;
  logic signed [RAMP_W-1:0] ramp_q;

  // result registers
  logic signed [SPD_W-1:0]  speed_out_q;
  logic signed [RAMP_W-1:0] ramp_out_q;
  logic                     stop_out_q;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q <= '0;
      fall_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RISE_TIME: rise_q <= cfg_data_i;
        CFG_FALL_TIME: fall_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position delta, saturated to 16 bits
  logic [POS_W-1:0]          diff;
  logic signed [DELTA_W-1:0] delta_sat;

  always_comb begin
    diff = encoder_position_i - last_pos_q;
    if ($signed(diff) > POS_W'(DELTA_MAX)) begin
      delta_sat = DELTA_W'(DELTA_MAX);
    end else if ($signed(diff) < POS_W'(DELTA_MIN)) begin
      delta_sat = DELTA_W'(DELTA_MIN);
    end else begin
      delta_sat = diff[DELTA_W-1:0];
    end
  end

  // delta ring
  logic [DELTA_W-1:0]        ring_rdata;
  logic signed [DELTA_W-1:0] ring_old;

  esrs_ram #(
    .WIDTH (DELTA_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ring),
    .waddr_i (ptr_q),
    .wdata_i (delta_q),
    .re_i    (cmd_i.load),
    .raddr_i (ptr_q),
    .rdata_o (ring_rdata)
  );

  assign ring_old = vld_q[ptr_q] ? $signed(ring_rdata) : '0;

  // speed product and its magnitude
  logic signed [PROD_W-1:0] sprod;
  logic signed [PROD_W-1:0] sprod_abs;

  always_comb begin
    sprod     = PROD_W'(total_q) * PROD_W'(SPEED_SCALE);
    sprod_abs = sprod[PROD_W-1] ? -sprod : sprod;
  end

  // target magnitude and goal
  logic [TGT_W-1:0]         mag;
  logic signed [RAMP_W-1:0] goal;
  logic                     rising;
  logic                     falling;

  always_comb begin
    mag     = tgt_q[TGT_W-1] ? TGT_W'(-tgt_q) : TGT_W'(tgt_q);
    goal    = latch_q ? '0 : RAMP_W'(tgt_q) * RAMP_W'(GOAL_SCALE);
    rising  = (ramp_q < goal);
    falling = (ramp_q > goal);
  end

  // ramp step divider
  logic [DVD_W-1:0]  div_dvd;
  logic [TIME_W-1:0] div_dvs;
  logic              div_busy;
  logic [DVD_W-1:0]  div_q;

  assign div_dvd = DVD_W'(rprod_q);
  assign div_dvs = rising ? rise_q : fall_q;

  esrs_div #(
    .DVD_W (DVD_W),
    .DVS_W (TIME_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  assign sts_o.div_busy = div_busy;

  // speed magnitude by reciprocal multiply, truncated
  logic [MAG_W+RCP_W-1:0]  spd_prod;
  logic signed [SPD_W-1:0] spd_abs;

  assign spd_prod = spd_dvd_q * RCP_W'(RCP);
  assign spd_abs  = spd_prod[RSH +: SPD_W];

  // ramp update, clamped at the goal
  logic [RPROD_W-1:0]       step;
  logic signed [WIDE_W-1:0] ramp_w, goal_w, step_w, next_w;
  logic signed [RAMP_W-1:0] ramp_nxt;

  always_comb begin
    step     = (div_q[RPROD_W-1:0] == '0) ? RPROD_W'(1) : div_q[RPROD_W-1:0];
    ramp_w   = WIDE_W'(ramp_q);
    goal_w   = WIDE_W'(goal);
    step_w   = $signed(WIDE_W'(step));
    next_w   = ramp_w;
    ramp_nxt = ramp_q;
    if (rising) begin
      if (rise_q == '0 || mag == '0) begin
        ramp_nxt = goal;
      end else begin
        next_w   = ramp_w + step_w;
        ramp_nxt = (next_w > goal_w) ? goal : next_w[RAMP_W-1:0];
      end
    end else if (falling) begin
      if (fall_q == '0 || mag == '0) begin
        ramp_nxt = goal;
      end else begin
        next_w   = ramp_w - step_w;
        ramp_nxt = (next_w < goal_w) ? goal : next_w[RAMP_W-1:0];
      end
    end
  end

  // control state of the estimator and ramp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= '0;
      latch_q    <= 1'b0;
      ptr_q      <= '0;
      vld_q      <= '0;
      total_q    <= '0;
      ramp_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        last_pos_q <= encoder_position_i;
        latch_q    <= latch_q | stop_event_i;
      end
      if (cmd_i.ring) begin
        total_q      <= total_q - SUM_W'(ring_old) + SUM_W'(delta_q);
        vld_q[ptr_q] <= 1'b1;
        ptr_q        <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
      end
      if (cmd_i.ramp_upd) begin
        ramp_q <= ramp_nxt;
      end
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delta_q <= delta_sat;
      tgt_q   <= target_rpm_i;
    end
    if (cmd_i.mul) begin
      spd_dvd_q <= sprod_abs[MAG_W-1:0];
      spd_neg_q <= total_q[SUM_W-1];
      rprod_q   <= RPROD_W'(mag) * RPROD_W'(RAMP_SCALE);
    end
    if (cmd_i.spd_cap) begin
      speed_q <= spd_neg_q ? -spd_abs : spd_abs;
    end
    if (cmd_i.out_load) begin
      speed_out_q <= speed_q;
      ramp_out_q  <= ramp_q;
      stop_out_q  <= latch_q;
    end
  end

  assign speed_decirpm_o      = speed_out_q;
  assign ramp_setpoint_mrpm_o = ramp_out_q;
  assign stop_active_o        = stop_out_q;

endmodule

FILE: rtl/core/encoder_speed_ramp_setpoint.sv
// a transaction runs through load, ring update, multiply, speed capture, the
// ramp step division in the 2-bit/cycle divider, ramp update and output load;
// a new transaction is taken only once the last result is in the output registers;
// the divider runs once per tick for the ramp step only
// reset: asynchronous, clears position, window sum, ring valid bits, ramp,
// stop latch and ramp times; input is ready from reset on, as reset puts the controller in idle
module encoder_speed_ramp_setpoint
  import esrs_pkg::*;
#(
  parameter int unsigned WINDOW = DEF_WINDOW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [POS_W-1:0]  encoder_position_i,
  input  logic signed [TGT_W-1:0]  target_rpm_i,
  input  logic                     stop_event_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SPD_W-1:0]  speed_decirpm_o,
  output logic signed [RAMP_W-1:0] ramp_setpoint_mrpm_o,
  output logic                     stop_active_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [TIME_W-1:0]        cfg_data_i
);

  // window sum width and divider width follow the window depth
  localparam int unsigned SUM_W  = $clog2(WINDOW) + DELTA_W;
  localparam int unsigned MAG_W  = SUM_W + 6;
  localparam int unsigned DVD_W  = (MAG_W > RPROD_W) ? MAG_W : RPROD_W;

  esrs_cmd_t cmd;
  esrs_sts_t sts;

  esrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  esrs_dpath #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .DVD_W  (DVD_W)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .encoder_position_i   (encoder_position_i),
    .target_rpm_i         (target_rpm_i),
    .stop_event_i         (stop_event_i),
    .speed_decirpm_o      (speed_decirpm_o),
    .ramp_setpoint_mrpm_o (ramp_setpoint_mrpm_o),
    .stop_active_o        (stop_active_o)
  );

  // register writes never stall
  assign cfg_ready_o = 1'b1;

endmodule

FILE: rtl/core/esrs_checker.sv
`include "assert_macros.svh"

module esrs_checker
  import esrs_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [SPD_W-1:0]  speed_decirpm_o,
  input logic signed [RAMP_W-1:0] ramp_setpoint_mrpm_o,
  input logic                     stop_active_o
);

  // a stalled result stays valid and keeps its speed and setpoint
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(ramp_setpoint_mrpm_o) && $stable(speed_decirpm_o))

  // one transaction in work at a time
  `ASSERT_CLK(a_single_txn, in_valid_i && in_ready_o |=> !in_ready_o)

  // the stop indication never clears without reset
  `ASSERT_CLK(a_stop_sticky, out_valid_o && stop_active_o |=> stop_active_o)

  // setpoint stays inside the target range
  `ASSERT_CLK(a_ramp_range, out_valid_o |-> ramp_setpoint_mrpm_o >= RAMP_MIN && ramp_setpoint_mrpm_o <= RAMP_MAX)

endmodule

bind encoder_speed_ramp_setpoint esrs_checker u_esrs_checker (.*);
